FILE: hw/rtl/assert_macros.svh
// Assertion shorthands used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SSL_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SSL_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/ssl_pkg.sv
package ssl_pkg;

   localparam int LEVEL_W     = 16;
   localparam int PHASE_W     = 32;
   localparam int STEPS       = 32;
   localparam int STEP_IDX_W  = 5;
   localparam int COUNT_W     = 6;
   localparam int SEL_W       = 3;
   localparam int SMOOTH_W    = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int WGT_W       = 36;
   localparam int ACC_W       = 52;
   localparam int TAPS        = 4;
   localparam int TAP_W       = 2;
   localparam int SPLINE_W    = 18;

   localparam logic [PHASE_W-1:0]  PHASE_INC_RESET = 32'd48696;
   localparam logic [LEVEL_W-1:0]  LEVEL_HALF      = 16'h8000;
   localparam logic [LEVEL_W-1:0]  LEVEL_MAX       = 16'hFFFF;
   // (2^19 + 1) / 3: exact divide by three for quotients below 2^19
   localparam logic [17:0]         DIV3_RECIP      = 18'd174763;

   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_INC = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_SEL  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTH    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC      = 3'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_READ_NEAR,
      ST_READ_FAR,
      ST_WEIGHT,
      ST_MAC,
      ST_DIVIDE,
      ST_BLEND,
      ST_OUTPUT
   } ssl_state_type;

   typedef struct packed {
      logic             tick_load;
      logic             table_write;
      logic             scale;
      logic             read_near;
      logic             read_far;
      logic             weight;
      logic             mac;
      logic             mac_first;
      logic [TAP_W-1:0] mac_sel;
      logic             divide;
      logic             blend;
      logic             out_load;
   } ssl_cmd_type;

   function automatic logic [COUNT_W-1:0] step_count(input logic [SEL_W-1:0] sel);
      logic [COUNT_W-1:0] n;
      case (sel)
         3'd0:    n = 6'd32;
         3'd1:    n = 6'd16;
         3'd2:    n = 6'd12;
         3'd3:    n = 6'd8;
         3'd4:    n = 6'd6;
         3'd5:    n = 6'd4;
         3'd6:    n = 6'd3;
         default: n = 6'd2;
      endcase
      return n;
   endfunction

endpackage

FILE: hw/rtl/ssl_ctrl.sv
module ssl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_action,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ssl_pkg::ssl_cmd_type cmd
);

   ssl_pkg::ssl_state_type         state_ff, state_in;
   logic [ssl_pkg::TAP_W-1:0]      tap_ff, tap_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           accept;
   logic                           out_free;

   assign accept    = req_valid && (state_ff == ssl_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ssl_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ssl_pkg::ST_IDLE: begin
            if (accept && !req_action) state_in = ssl_pkg::ST_SCALE;
         end
         ssl_pkg::ST_SCALE:     state_in = ssl_pkg::ST_READ_NEAR;
         ssl_pkg::ST_READ_NEAR: state_in = ssl_pkg::ST_READ_FAR;
         ssl_pkg::ST_READ_FAR:  state_in = ssl_pkg::ST_WEIGHT;
         ssl_pkg::ST_WEIGHT:    state_in = ssl_pkg::ST_MAC;
         ssl_pkg::ST_MAC: begin
            if (tap_ff == ssl_pkg::TAP_W'(ssl_pkg::TAPS - 1)) state_in = ssl_pkg::ST_DIVIDE;
         end
         ssl_pkg::ST_DIVIDE:    state_in = ssl_pkg::ST_BLEND;
         ssl_pkg::ST_BLEND:     state_in = ssl_pkg::ST_OUTPUT;
         ssl_pkg::ST_OUTPUT: begin
            if (out_free) state_in = ssl_pkg::ST_IDLE;
         end
         default:               state_in = ssl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd             = '0;
      cmd.tick_load   = accept && !req_action;
      cmd.table_write = accept && req_action;
      cmd.mac_sel     = tap_ff;
      unique case (state_ff)
         ssl_pkg::ST_SCALE:     cmd.scale     = 1'b1;
         ssl_pkg::ST_READ_NEAR: cmd.read_near = 1'b1;
         ssl_pkg::ST_READ_FAR:  cmd.read_far  = 1'b1;
         ssl_pkg::ST_WEIGHT:    cmd.weight    = 1'b1;
         ssl_pkg::ST_MAC: begin
            cmd.mac       = 1'b1;
            cmd.mac_first = (tap_ff == '0);
         end
         ssl_pkg::ST_DIVIDE:    cmd.divide    = 1'b1;
         ssl_pkg::ST_BLEND:     cmd.blend     = 1'b1;
         ssl_pkg::ST_OUTPUT:    cmd.out_load  = out_free;
         default: ;
      endcase
   end

   // step through the four spline taps; wraps back to zero after the last
   assign tap_in       = (state_ff == ssl_pkg::ST_MAC) ? tap_ff + 1'b1 : tap_ff;
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssl_pkg::ST_IDLE;
         tap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hw/rtl/ssl_dp.sv
module ssl_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  ssl_pkg::ssl_cmd_type              cmd,
   input  logic [ssl_pkg::STEP_IDX_W-1:0]    req_step_index,
   input  logic [ssl_pkg::LEVEL_W-1:0]       req_step_level,
   input  logic                              req_bar_start,
   input  logic                              csr_write_en,
   input  logic [ssl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ssl_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic [ssl_pkg::LEVEL_W-1:0]       rsp_lfo_value
);

   // control registers
   logic [ssl_pkg::PHASE_W-1:0]    phase_inc_ff;
   logic [ssl_pkg::SEL_W-1:0]      step_sel_ff;
   logic [ssl_pkg::SMOOTH_W-1:0]   smooth_ff;
   logic                           sync_en_ff;

   logic [ssl_pkg::PHASE_W-1:0]    phase_ff, phase_in;
   logic [ssl_pkg::COUNT_W-1:0]    n;
   logic [37:0]                    prod;
   logic [ssl_pkg::STEP_IDX_W-1:0] idx_ff;
   logic [15:0]                    t_ff;

   logic [ssl_pkg::COUNT_W-1:0]    idx_ext, prev, nxt1_raw, nxt1, nxt2_raw, nxt2;
   logic [ssl_pkg::STEP_IDX_W-1:0] addr_a, addr_b;

   logic [ssl_pkg::LEVEL_W-1:0]    step_mem_ff [ssl_pkg::STEPS];
   logic [ssl_pkg::STEPS-1:0]      step_vld_ff;
   logic [ssl_pkg::LEVEL_W-1:0]    rd_a_mem_ff, rd_b_mem_ff, rd_a, rd_b;
   logic                           rd_a_vld_ff, rd_b_vld_ff;

   logic [31:0]                    t2_ff;
   logic [47:0]                    t3_ff;
   logic [49:0]                    t3x3;
   logic [ssl_pkg::WGT_W-1:0]      t_sh, t_sh3, t2x3, t2x6;
   logic [ssl_pkg::WGT_W-1:0]      t3_ceil, t3x3_floor, t3x3_ceil;
   logic [ssl_pkg::WGT_W-1:0]      w_in [ssl_pkg::TAPS];
   logic [ssl_pkg::WGT_W-1:0]      w_ff [ssl_pkg::TAPS];
   logic [ssl_pkg::LEVEL_W-1:0]    p_ff [ssl_pkg::TAPS];

   logic [ssl_pkg::ACC_W-1:0]      mac_prod, acc_ff, acc_in, acc_round;
   logic [18:0]                    div_q;
   logic [36:0]                    div_prod;
   logic [ssl_pkg::SPLINE_W-1:0]   sp_ff;
   logic [16:0]                    smooth_inv;
   logic [32:0]                    mix_ff;
   logic [34:0]                    blend_sum;
   logic [18:0]                    blend_v;
   logic [ssl_pkg::LEVEL_W-1:0]    lfo_in, lfo_ff;

   localparam logic [ssl_pkg::WGT_W-1:0] ONE_Q32  = 36'h1_0000_0000;
   localparam logic [ssl_pkg::WGT_W-1:0] FOUR_Q32 = 36'h4_0000_0000;
   localparam logic [ssl_pkg::ACC_W-1:0] ROUND    = 52'h3_0000_0000;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_inc_ff <= ssl_pkg::PHASE_INC_RESET;
         step_sel_ff  <= '0;
         smooth_ff    <= '0;
         sync_en_ff   <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            ssl_pkg::CSR_PHASE_INC: phase_inc_ff <= csr_data[ssl_pkg::PHASE_W-1:0];
            ssl_pkg::CSR_STEP_SEL:  step_sel_ff  <= csr_data[ssl_pkg::SEL_W-1:0];
            ssl_pkg::CSR_SMOOTH:    smooth_ff    <= csr_data[ssl_pkg::SMOOTH_W-1:0];
            ssl_pkg::CSR_SYNC:      sync_en_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // advance the phase, or clear it on a synced bar start
   assign phase_in = (sync_en_ff && req_bar_start) ? '0 : phase_ff + phase_inc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (cmd.tick_load) begin
         phase_ff <= phase_in;
      end
   end

   assign n    = ssl_pkg::step_count(step_sel_ff);
   assign prod = 38'(phase_ff) * 38'(n);

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         idx_ff <= prod[36:32];
         t_ff   <= prod[31:16];
      end
   end

   // circular neighbors within the active step count
   always_comb begin
      idx_ext  = {1'b0, idx_ff};
      prev     = (idx_ff == '0) ? n - 6'd1 : idx_ext - 6'd1;
      nxt1_raw = idx_ext + 6'd1;
      nxt1     = (nxt1_raw == n) ? '0 : nxt1_raw;
      nxt2_raw = idx_ext + 6'd2;
      nxt2     = (nxt2_raw >= n) ? nxt2_raw - n : nxt2_raw;
      addr_a   = cmd.read_far ? nxt1[ssl_pkg::STEP_IDX_W-1:0] : prev[ssl_pkg::STEP_IDX_W-1:0];
      addr_b   = cmd.read_far ? nxt2[ssl_pkg::STEP_IDX_W-1:0] : idx_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.table_write) begin
         step_mem_ff[req_step_index] <= req_step_level;
      end
      if (cmd.read_near || cmd.read_far) begin
         rd_a_mem_ff <= step_mem_ff[addr_a];
         rd_b_mem_ff <= step_mem_ff[addr_b];
         rd_a_vld_ff <= step_vld_ff[addr_a];
         rd_b_vld_ff <= step_vld_ff[addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_vld_ff <= '0;
      end else if (cmd.table_write) begin
         step_vld_ff[req_step_index] <= 1'b1;
      end
   end

   // an entry never written reads as one half
   assign rd_a = rd_a_vld_ff ? rd_a_mem_ff : ssl_pkg::LEVEL_HALF;
   assign rd_b = rd_b_vld_ff ? rd_b_mem_ff : ssl_pkg::LEVEL_HALF;

   // B-spline basis weights in Q32, floor of the exact Q48 polynomials
   always_comb begin
      t3x3       = 50'(t3_ff) + 50'({t3_ff, 1'b0});
      t_sh       = 36'({t_ff, 16'b0});
      t_sh3      = t_sh + {t_sh[34:0], 1'b0};
      t2x3       = 36'(t2_ff) + 36'({t2_ff, 1'b0});
      t2x6       = {t2x3[34:0], 1'b0};
      t3_ceil    = 36'(t3_ff[47:16]) + 36'(t3_ff[15:0] != '0);
      t3x3_floor = 36'(t3x3[49:16]);
      t3x3_ceil  = t3x3_floor + 36'(t3x3[15:0] != '0);
      w_in[0]    = ONE_Q32 + t2x3 - t_sh3 - t3_ceil;
      w_in[1]    = FOUR_Q32 - t2x6 + t3x3_floor;
      w_in[2]    = ONE_Q32 + t_sh3 + t2x3 - t3x3_ceil;
      w_in[3]    = 36'(t3_ff[47:16]);
   end

   always_ff @(posedge clock) begin
      if (cmd.read_near) begin
         t2_ff <= 32'(t_ff) * 32'(t_ff);
      end
      if (cmd.read_far) begin
         t3_ff   <= 48'(t2_ff) * 48'(t_ff);
         p_ff[0] <= rd_a;
         p_ff[1] <= rd_b;
      end
      if (cmd.weight) begin
         p_ff[2] <= rd_a;
         p_ff[3] <= rd_b;
         for (int k = 0; k < ssl_pkg::TAPS; k++) begin
            w_ff[k] <= w_in[k];
         end
      end
   end

   assign mac_prod = 52'(w_ff[cmd.mac_sel]) * 52'(p_ff[cmd.mac_sel]);
   assign acc_in   = (cmd.mac_first ? '0 : acc_ff) + mac_prod;

   // spline = floor((acc + 3*2^32) / (6*2^32)): shift by 33, then divide by three
   assign acc_round = acc_ff + ROUND;
   assign div_q     = acc_round[51:33];
   assign div_prod  = 37'(div_q) * 37'(ssl_pkg::DIV3_RECIP);

   assign smooth_inv = 17'h1_0000 - 17'(smooth_ff);
   assign blend_sum  = 35'(mix_ff) + 35'(smooth_ff) * 35'(sp_ff) + 35'h8000;
   assign blend_v    = blend_sum[34:16];
   assign lfo_in     = (blend_v > 19'(ssl_pkg::LEVEL_MAX)) ? ssl_pkg::LEVEL_MAX
                                                           : blend_v[15:0];

   always_ff @(posedge clock) begin
      if (cmd.mac) begin
         acc_ff <= acc_in;
      end
      if (cmd.divide) begin
         sp_ff <= div_prod[36:19];
      end
      if (cmd.blend) begin
         mix_ff <= 33'(smooth_inv) * 33'(p_ff[1]);
      end
      if (cmd.out_load) begin
         lfo_ff <= lfo_in;
      end
   end

   assign rsp_lfo_value = lfo_ff;

endmodule

FILE: hw/rtl/step_sequencer_lfo.sv
// Tick word: the result word is registered; a new word is taken only once the result
// register has loaded and the block is idle again, since the single multiply-accumulate
// unit steps over the four spline taps; a stalled result word also holds off the next tick.
// Step write word: taken when idle, no result word.
// Synchronous reset: phase to zero, registers to defaults, every step reads one half.
`include "assert_macros.svh"

module step_sequencer_lfo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_action,
   input  logic [ssl_pkg::STEP_IDX_W-1:0]    req_step_index,
   input  logic [ssl_pkg::LEVEL_W-1:0]       req_step_level,
   input  logic                              req_bar_start,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ssl_pkg::LEVEL_W-1:0]       rsp_lfo_value,
   input  logic                              csr_write_en,
   input  logic [ssl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ssl_pkg::CSR_DATA_W-1:0]    csr_data
);

   ssl_pkg::ssl_cmd_type cmd;

   ssl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd)
   );

   ssl_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_step_index (req_step_index),
      .req_step_level (req_step_level),
      .req_bar_start  (req_bar_start),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_lfo_value  (rsp_lfo_value)
   );

   `SSL_ASSERT_NEXT(a_write_silent, clock, reset, req_valid && !req_stall && req_action && !rsp_valid, !rsp_valid, "step write raised a result word")
   `SSL_ASSERT_NEXT(a_tick_busy, clock, reset, req_valid && !req_stall && !req_action, req_stall, "tick accepted but block not busy")
   `SSL_ASSERT_IMPLY(a_rsp_from_work, clock, reset, $rose(rsp_valid), $past(req_stall), "result word without a tick in flight")

endmodule

FILE: dv/step_sequencer_lfo_tb.sv
`timescale 1ns / 100ps

module step_sequencer_lfo_tb;
   import ssl_pkg::*;

   localparam logic ACT_TICK  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;
   // Index past the last register; a write there must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd5;

   localparam int SETTLE_CYCLES   = 16;
   localparam int QUIET_LIMIT     = 2000;
   localparam int NUM_PHASES      = 8;
   localparam int WORDS_PER_PHASE = 50;
   localparam int MAX_REPORTS     = 10;

   typedef enum logic {ROW_WORD, ROW_REG} row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      logic                     action;
      logic [STEP_IDX_W-1:0]    index;
      logic [LEVEL_W-1:0]       level;
      logic                     bar;
      logic [CSR_INDEX_W-1:0]   reg_index;
      logic [CSR_DATA_W-1:0]    reg_data;
      logic                     typed;
      logic [LEVEL_W-1:0]       lfo;
   } stim_row_type;

   localparam int NUM_ROWS = 31;
   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      // fresh table: every step reads one half, no smoothing
      '{ROW_WORD, ACT_TICK,  5'd0,  16'h0000, 1'b0, CSR_PHASE_INC, 32'd0, 1'b1, 16'h8000},
      // bar start while sync is off
      '{ROW_WORD, ACT_TICK,  5'd31, 16'hFFFF, 1'b1, CSR_PHASE_INC, 32'd0, 1'b1, 16'h8000},
      // bar start on a write
      '{ROW_WORD, ACT_WRITE, 5'd0,  16'hFFFF, 1'b1, CSR_PHASE_INC, 32'd0, 1'b0, 16'h0000},
      '{ROW_WORD, ACT_TICK,  5'd0,  16'h0000, 1'b0, CSR_PHASE_INC, 32'd0, 1'b1, 16'hFFFF},
      '{ROW_WORD, ACT_WRITE, 5'd31, 16'h0000, 1'b0, CSR_PHASE_INC, 32'd0, 1'b0, 16'h0000},
      '{ROW_WORD, ACT_WRITE, 5'd0,  16'h0000, 1'b0, CSR_PHASE_INC, 32'd0, 1'b0, 16'h0000},
      '{ROW_WORD, ACT_TICK,  5'd0,  16'h0000, 1'b0, CSR_PHASE_INC, 32'd0, 1'b1, 16'h0000},
      '{ROW_REG,  ACT_TICK,  5'd0,  16'h0000, 1'b0, CSR_UNUSED, 32'hFFFF_FFFF, 1'b0, 16'h0000},
      '{ROW_WORD, ACT_TICK,  5'd0,  16'h0000, 1'b0, CSR_PHASE_INC, 32'd0, 1'b1, 16'h0000},
      '{ROW_REG,  ACT_TICK,  5'd0,  16'h0000, 1'b0, CSR_SYNC,   32'd1, 1'b0, 16'h0000},
      '{ROW_WORD, ACT_TICK,  5'd0,  16'h0000, 1'b1, CSR_PHASE_INC, 32'd0, 1'b1, 16'h0000},
      '{ROW_WORD, ACT_WRITE, 5'd1,  16'h4000, 1'b0, CSR_PHASE_INC, 32'd0, 1'b0, 16'h0000},
      '{ROW_WORD, ACT_WRITE, 5'd2,  16'hFFFF, 1'b0, CSR_PHASE_INC, 32'd0, 1'b0, 16'h0000},
      '{ROW_REG,  ACT_TICK,  5'd0,  16'h0000, 1'b0, CSR_PHASE_INC, 32'hFFFF_FFFF, 1'b0, 16'h0000},
      // phase lands just below one cycle: last step
      '{ROW_WORD, ACT_TICK,  5'd0,  16'h0000, 1'b0, CSR_PHASE_INC, 32'd0, 1'b1, 16'h0000},
      '{ROW_WORD, ACT_TICK,  5'd0,  16'h0000, 1'b0, CSR_PHASE_INC, 32'd0, 1'b0, 16'h0000},
      '{ROW_REG,  ACT_TICK,  5'd0,  16'h0000, 1'b0, CSR_SMOOTH, 32'h0000_FFFF, 1'b0, 16'h0000},
      '{ROW_WORD, ACT_TICK,  5'd0,  16'h0000, 1'b0, CSR_PHASE_INC, 32'd0, 1'b0, 16'h0000},
      '{ROW_REG,  ACT_TICK,  5'd0,  16'h0000, 1'b0, CSR_STEP_SEL, 32'd7, 1'b0, 16'h0000},
      '{ROW_WORD, ACT_TICK,  5'd0,  16'h0000, 1'b0, CSR_PHASE_INC, 32'd0, 1'b0, 16'h0000},
      '{ROW_REG,  ACT_TICK,  5'd0,  16'h0000, 1'b0, CSR_STEP_SEL, 32'd2, 1'b0, 16'h0000},
      '{ROW_REG,  ACT_TICK,  5'd0,  16'h0000, 1'b0, CSR_PHASE_INC, 32'd0, 1'b0, 16'h0000},
      '{ROW_WORD, ACT_TICK,  5'd0,  16'h0000, 1'b1, CSR_PHASE_INC, 32'd0, 1'b0, 16'h0000},
      '{ROW_WORD, ACT_TICK,  5'd0,  16'h0000, 1'b0, CSR_PHASE_INC, 32'd0, 1'b0, 16'h0000},
      '{ROW_REG,  ACT_TICK,  5'd0,  16'h0000, 1'b0, CSR_SMOOTH, 32'h0000_8000, 1'b0, 16'h0000},
      '{ROW_REG,  ACT_TICK,  5'd0,  16'h0000, 1'b0, CSR_PHASE_INC, 32'h1555_5555, 1'b0, 16'h0000},
      '{ROW_WORD, ACT_TICK,  5'd0,  16'h0000, 1'b0, CSR_PHASE_INC, 32'd0, 1'b0, 16'h0000},
      '{ROW_WORD, ACT_TICK,  5'd0,  16'h0000, 1'b1, CSR_PHASE_INC, 32'd0, 1'b0, 16'h0000},
      '{ROW_REG,  ACT_TICK,  5'd0,  16'h0000, 1'b0, CSR_SYNC,   32'd0, 1'b0, 16'h0000},
      '{ROW_WORD, ACT_TICK,  5'd0,  16'h0000, 1'b1, CSR_PHASE_INC, 32'd0, 1'b0, 16'h0000},
      '{ROW_WORD, ACT_TICK,  5'd0,  16'h0000, 1'b0, CSR_PHASE_INC, 32'd0, 1'b0, 16'h0000}
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_action = 1'b0;
   logic [STEP_IDX_W-1:0]    req_step_index = '0;
   logic [LEVEL_W-1:0]       req_step_level = '0;
   logic                     req_bar_start = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [LEVEL_W-1:0]       rsp_lfo_value;
   logic                     csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_data = '0;

   // predictor state and register copies
   logic [31:0]              lfo_phase = 32'd0;
   logic [15:0]              level_store [32];
   logic [31:0]              cfg_increment = 32'd48696;
   logic [2:0]               cfg_count_sel = 3'd0;
   logic [15:0]              cfg_smoothing = 16'd0;
   logic                     cfg_sync = 1'b0;

   logic [15:0]              lfo_expect_q [$];
   int unsigned              fault_count = 0;
   int unsigned              quiet_cycles = 0;
   int unsigned              stall_left = 0;
   logic                     idling = 1'b1;

   step_sequencer_lfo DUT (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic void report_fault(input string msg);
      fault_count++;
      if (fault_count <= MAX_REPORTS) $display("%s", msg);
   endfunction

   // Advance the phase and work out the blended step level for one tick.
   function automatic logic [15:0] lfo_tick(input logic bar);
      logic [63:0] n, prod, idx, t, u, t2, t3, s3, w0, w1, w2, w3;
      logic [63:0] raw, prev, next, next2, acc, spline, s, v;
      lfo_phase = lfo_phase + cfg_increment;
      if (cfg_sync && bar) lfo_phase = 32'd0;
      case (cfg_count_sel)
         3'd0:    n = 64'd32;
         3'd1:    n = 64'd16;
         3'd2:    n = 64'd12;
         3'd3:    n = 64'd8;
         3'd4:    n = 64'd6;
         3'd5:    n = 64'd4;
         3'd6:    n = 64'd3;
         default: n = 64'd2;
      endcase
      prod = {32'd0, lfo_phase} * n;
      idx  = prod >> 32;
      t    = {48'd0, prod[31:16]};
      raw   = {48'd0, level_store[idx[4:0]]};
      prev  = {48'd0, level_store[5'((idx + n - 64'd1) % n)]};
      next  = {48'd0, level_store[5'((idx + 64'd1) % n)]};
      next2 = {48'd0, level_store[5'((idx + 64'd2) % n)]};
      u  = 64'd65536 - t;
      t2 = t * t;
      t3 = t2 * t;
      s3 = 64'd1 << 48;
      w0 = (u * u * u) >> 16;
      w1 = (64'd4 * s3 + 64'd3 * t3 - 64'd6 * t2 * 64'd65536) >> 16;
      w2 = (s3 + 64'd3 * t * (64'd1 << 32) + 64'd3 * t2 * 64'd65536 - 64'd3 * t3) >> 16;
      w3 = t3 >> 16;
      acc = w0 * prev + w1 * raw + w2 * next + w3 * next2;
      spline = (acc + (64'd3 << 32)) / (64'd6 << 32);
      s = {48'd0, cfg_smoothing};
      v = ((64'd65536 - s) * raw + s * spline + 64'd32768) >> 16;
      if (v > 64'd65535) v = 64'd65535;
      return v[15:0];
   endfunction

   // Hold the word until taken, then record what it should produce.
   task automatic send_word(input logic action, input logic [4:0] index,
                            input logic [15:0] level, input logic bar,
                            input logic typed, input logic [15:0] typed_lfo);
      logic [15:0] predicted;
      if (idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= action;
      req_step_index <= index;
      req_step_level <= level;
      req_bar_start  <= bar;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (action == ACT_WRITE) begin
         level_store[index] = level;
      end else begin
         predicted = lfo_tick(bar);
         lfo_expect_q.push_back(typed ? typed_lfo : predicted);
      end
   endtask

   // Drop valid and wait out every pending word before touching registers.
   task automatic settle();
      req_valid <= 1'b0;
      while (lfo_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= data;
      @(posedge clock);
      case (idx)
         CSR_PHASE_INC: cfg_increment = data;
         CSR_STEP_SEL:  cfg_count_sel = data[2:0];
         CSR_SMOOTH:    cfg_smoothing = data[15:0];
         CSR_SYNC:      cfg_sync      = data[0];
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      logic [15:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (lfo_expect_q.size() == 0) begin
            report_fault($sformatf("unexpected result word, lfo_value %h", rsp_lfo_value));
         end else begin
            want = lfo_expect_q.pop_front();
            if (rsp_lfo_value !== want)
               report_fault($sformatf("lfo_value mismatch: expected %h, got %h",
                                      want, rsp_lfo_value));
         end
      end
      if (reset || csr_write_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (idling && !reset && $urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("** step_sequencer_lfo: FAILED **");
      $finish;
   end

   initial begin
      logic [31:0]  inc_pick;
      logic [31:0]  junk;
      logic [2:0]   sel_pick;
      logic [15:0]  smooth_pick;
      logic         sync_pick;
      logic         act;
      logic [15:0]  lvl;
      stim_row_type row;

      for (int k = 0; k < 32; k++) level_store[k] = 16'h8000;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NUM_ROWS; r++) begin
         row = DIRECTED_ROWS[r];
         if (row.kind == ROW_REG) begin
            settle();
            program_reg(row.reg_index, row.reg_data);
            csr_write_en <= 1'b0;
         end else begin
            send_word(row.action, row.index, row.level, row.bar, row.typed, row.lfo);
         end
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         settle();
         // last phase runs with both sides at full rate
         idling = (ph != NUM_PHASES - 1);
         case (ph)
            0: begin
               inc_pick = 32'hFFFF_FFFF; sel_pick = 3'd7;
               smooth_pick = 16'hFFFF; sync_pick = 1'b1;
            end
            1: begin
               inc_pick = $urandom; sel_pick = 3'd0;
               smooth_pick = 16'h0000; sync_pick = 1'b0;
            end
            default: begin
               case ($urandom_range(0, 3))
                  0:       inc_pick = $urandom_range(1, 32'h0010_0000);
                  1:       inc_pick = $urandom;
                  2:       inc_pick = 32'h8000_0000;
                  default: inc_pick = $urandom_range(32'h0400_0000, 32'h2000_0000);
               endcase
               sel_pick = 3'(ph - 1);
               case ($urandom_range(0, 3))
                  0:       smooth_pick = 16'h0000;
                  1:       smooth_pick = 16'hFFFF;
                  default: smooth_pick = 16'($urandom_range(0, 65535));
               endcase
               sync_pick = 1'($urandom_range(0, 1));
            end
         endcase
         junk = $urandom;
         program_reg(3'($urandom_range(4, 7)), junk);
         program_reg(CSR_PHASE_INC, inc_pick);
         program_reg(CSR_STEP_SEL, {junk[31:3], sel_pick});
         program_reg(CSR_SMOOTH, {junk[31:16], smooth_pick});
         program_reg(CSR_SYNC, {junk[31:1], sync_pick});
         csr_write_en <= 1'b0;

         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            act = ($urandom_range(0, 9) < 3) ? ACT_WRITE : ACT_TICK;
            lvl = 16'($urandom_range(0, 65535));
            case ($urandom_range(0, 7))
               0:       lvl = 16'h0000;
               1:       lvl = 16'hFFFF;
               default: ;
            endcase
            send_word(act, 5'($urandom_range(0, 31)), lvl,
                      ($urandom_range(0, 7) == 0), 1'b0, 16'h0000);
         end
      end

      req_valid <= 1'b0;
      while (lfo_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (lfo_expect_q.size() != 0)
         report_fault($sformatf("%0d result words never arrived", lfo_expect_q.size()));
      if (fault_count == 0)
         $display("** step_sequencer_lfo: PASSED **");
      else
         $display("** step_sequencer_lfo: FAILED **");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/ssl_pkg.sv
hw/rtl/ssl_ctrl.sv
hw/rtl/ssl_dp.sv
hw/rtl/step_sequencer_lfo.sv
dv/step_sequencer_lfo_tb.sv
